@@ hdl/urs_pkg.sv @@
// ----------------------------------------------------------------------------
// Ultrasonic ranging sequencer package
// Shared types, register indexes, arithmetic constants and cycle helpers.
// ----------------------------------------------------------------------------
package urs_pkg;

  localparam int unsigned NumSensors = 3;

  // Sequencer modes.
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_WAIT  = 2'd1,
    MODE_GUARD = 2'd2
  } mode_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_SENSOR_PRESENT  = 3'd0,
    CFG_MAX_DISTANCE_MM = 3'd1,
    CFG_MIN_DISTANCE_MM = 3'd2,
    CFG_ECHO_TIMEOUT_US = 3'd3,
    CFG_GUARD_TIME_US   = 3'd4,
    CFG_SLOT_TIME_US    = 3'd5
  } cfg_idx_e;

  // Sensor codes.
  localparam logic [1:0] SensorFront = 2'd0;
  localparam logic [1:0] SensorLeft  = 2'd1;
  localparam logic [1:0] SensorRight = 2'd2;

  // Register reset values.
  localparam logic [2:0]  PresentReset = 3'd7;
  localparam logic [15:0] MaxDistReset = 16'd4000;
  localparam logic [15:0] MinDistReset = 16'd20;
  localparam logic [19:0] TimeoutReset = 20'd30000;
  localparam logic [19:0] GuardReset   = 20'd10000;
  localparam logic [19:0] SlotReset    = 20'd60000;

  // Distance arithmetic: mm = (pulse * 343 + 1000) / 2000.
  localparam logic [40:0] DistMul   = 41'd343;
  localparam logic [40:0] DistRound = 41'd1000;
  // Numerators at or above this give more than 65535 mm.
  localparam logic [40:0] DistLimit = 41'd131072000;
  // Division by 125 after a shift by four: reciprocal of 2^30 / 125.
  localparam logic [23:0] Recip125  = 24'd8589934;
  localparam logic [23:0] Div125    = 24'd125;

  localparam logic [15:0] AgeSat = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  present;
    logic [15:0] max_mm;
    logic [15:0] min_mm;
    logic [19:0] timeout_us;
    logic [19:0] guard_us;
    logic [19:0] slot_us;
  } cfg_t;

  // One tick as it travels down the pipeline.
  typedef struct packed {
    logic        en;
    logic [31:0] now_us;
    logic [31:0] now_ms;
    logic        echo;
  } item_t;

  // Tick with its finished distance.
  typedef struct packed {
    item_t       item;
    logic [15:0] dist_mm;
    logic        bad;
  } meas_t;

  // Measurement outcome from the sequencer to the filters.
  typedef struct packed {
    logic        clear;
    logic        done;
    logic        ok;
    logic [1:0]  sensor;
    logic [15:0] mm;
  } flt_cmd_t;

  // Per-filter control.
  typedef struct packed {
    logic        clear;
    logic        accept;
    logic        reject;
    logic [15:0] mm;
  } flt_ctl_t;

  // Sequencer part of one result.
  typedef struct packed {
    logic        fire;
    logic [1:0]  fire_sensor;
    logic        cancel;
    logic [15:0] seq;
  } seq_res_t;

  // Number of slots in the firing cycle.
  function automatic logic [2:0] cycle_len(input logic [2:0] present);
    logic f, l, r;
    f = present[0];
    l = present[1];
    r = present[2];
    return {2'd0, f} + {2'd0, l} + {2'd0, f & r} + {2'd0, r};
  endfunction

  // Sensor at a slot of the firing cycle.
  function automatic logic [1:0] cycle_entry(input logic [2:0] present,
                                             input logic [1:0] pos);
    logic [1:0] seq [4];
    logic [2:0] n;
    seq[0] = SensorFront;
    seq[1] = SensorFront;
    seq[2] = SensorFront;
    seq[3] = SensorFront;
    n = 3'd0;
    if (present[0]) begin
      seq[n[1:0]] = SensorFront;
      n = n + 3'd1;
    end
    if (present[1]) begin
      seq[n[1:0]] = SensorLeft;
      n = n + 3'd1;
    end
    if (present[0] && present[2]) begin
      seq[n[1:0]] = SensorFront;
      n = n + 3'd1;
    end
    if (present[2]) begin
      seq[n[1:0]] = SensorRight;
    end
    return seq[pos];
  endfunction

endpackage

@@ hdl/urs_dist.sv @@
// ----------------------------------------------------------------------------
// Distance pipeline
// Input register and three stages that turn echo times into millimetres.
// ----------------------------------------------------------------------------
module urs_dist (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           in_valid_i,
  input  urs_pkg::item_t item_i,
  input  logic [31:0]    rise_i,
  input  logic [31:0]    fall_i,
  output logic           out_valid_o,
  output urs_pkg::meas_t meas_o
);
  import urs_pkg::*;

  logic        s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  item_t       s1_item_q, s2_item_q, s3_item_q, s4_item_q;
  logic [31:0] s1_rise_q, s1_fall_q;
  logic [40:0] s2_n_q, s2_n_d;
  logic        s2_zero_q, s2_zero_d;
  logic [46:0] s3_px_q, s3_px_d;
  logic [22:0] s3_x_q;
  logic        s3_bad_q, s3_bad_d;
  logic [15:0] s4_dist_q, s4_dist_d;
  logic        s4_bad_q;
  logic [31:0] pulse;
  logic [16:0] q_est, q_fix;
  logic [23:0] q_mul, rem;

  // Stage one: pulse width, times 343, plus rounding.
  assign pulse     = s1_fall_q - s1_rise_q;
  assign s2_zero_d = (pulse == 32'd0);
  assign s2_n_d    = ({9'd0, pulse} * DistMul) + DistRound;

  // Stage two: range check and reciprocal product for the divide by 2000.
  assign s3_bad_d = s2_zero_q || (s2_n_q >= DistLimit);
  assign s3_px_d  = {24'd0, s2_n_q[26:4]} * {23'd0, Recip125};

  // Stage three: the estimate is exact or one low; one compare fixes it.
  assign q_est     = s3_px_q[46:30];
  assign q_mul     = {7'd0, q_est} * Div125;
  assign rem       = {1'b0, s3_x_q} - q_mul;
  assign q_fix     = (rem >= Div125) ? (q_est + 17'd1) : q_est;
  assign s4_dist_d = q_fix[15:0];

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else if (adv_i) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_item_q <= item_i;
      s1_rise_q <= rise_i;
      s1_fall_q <= fall_i;
      s2_item_q <= s1_item_q;
      s2_n_q    <= s2_n_d;
      s2_zero_q <= s2_zero_d;
      s3_item_q <= s2_item_q;
      s3_px_q   <= s3_px_d;
      s3_x_q    <= s2_n_q[26:4];
      s3_bad_q  <= s3_bad_d;
      s4_item_q <= s3_item_q;
      s4_dist_q <= s4_dist_d;
      s4_bad_q  <= s3_bad_q;
    end
  end

  assign out_valid_o    = s4_v_q;
  assign meas_o.item    = s4_item_q;
  assign meas_o.dist_mm = s4_dist_q;
  assign meas_o.bad     = s4_bad_q;

endmodule

@@ hdl/urs_filter.sv @@
// ----------------------------------------------------------------------------
// Median-of-3 distance filter
// Sample store, filtered value and age for one sensor.
// ----------------------------------------------------------------------------
module urs_filter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  urs_pkg::flt_ctl_t ctl_i,
  input  logic [31:0]       now_ms_i,
  output logic [15:0]       dist_o,
  output logic              valid_o,
  output logic [15:0]       age_o
);
  import urs_pkg::*;

  logic [15:0] samp_q [3];
  logic [15:0] samp_d [3];
  logic [1:0]  cnt_q, cnt_d, ws_q, ws_d, w;
  logic [15:0] filt_q, filt_d;
  logic [31:0] lvt_q, lvt_d, age_diff;
  logic        hv_q, hv_d, ok_q, ok_d;

  // Output of the filter for a given fill level.
  function automatic logic [15:0] filter_out(input logic [15:0] a, input logic [15:0] b,
                                             input logic [15:0] c, input logic [1:0] n);
    logic [16:0] sum;
    logic [15:0] res;
    sum = {1'b0, a} + {1'b0, b};
    if (n == 2'd0) begin
      res = 16'd0;
    end else if (n == 2'd1) begin
      res = a;
    end else if (n == 2'd2) begin
      res = sum[16:1];
    end else if ((a <= b && b <= c) || (c <= b && b <= a)) begin
      res = b;
    end else if ((b <= a && a <= c) || (c <= a && a <= b)) begin
      res = a;
    end else begin
      res = c;
    end
    return res;
  endfunction

  // Write slot, taken modulo three.
  assign w = (ws_q == 2'd3) ? 2'd0 : ws_q;

  // Next state: a clear wins, then an accepted or a rejected attempt.
  always_comb begin
    samp_d = samp_q;
    cnt_d  = cnt_q;
    ws_d   = ws_q;
    filt_d = filt_q;
    lvt_d  = lvt_q;
    hv_d   = hv_q;
    ok_d   = ok_q;
    priority if (ctl_i.clear) begin
      samp_d[0] = 16'd0;
      samp_d[1] = 16'd0;
      samp_d[2] = 16'd0;
      cnt_d     = 2'd0;
      ws_d      = 2'd0;
      filt_d    = 16'd0;
      lvt_d     = 32'd0;
      hv_d      = 1'b0;
      ok_d      = 1'b0;
    end else if (ctl_i.accept) begin
      samp_d[w] = ctl_i.mm;
      ws_d      = (w == 2'd2) ? 2'd0 : (w + 2'd1);
      cnt_d     = (cnt_q == 2'd3) ? 2'd3 : (cnt_q + 2'd1);
      filt_d    = filter_out(samp_d[0], samp_d[1], samp_d[2], cnt_d);
      lvt_d     = now_ms_i;
      hv_d      = 1'b1;
      ok_d      = 1'b1;
    end else if (ctl_i.reject) begin
      ok_d = 1'b0;
    end else begin
      ok_d = ok_q;
    end
  end

  // Snapshot after this tick's update.
  assign age_diff = now_ms_i - lvt_d;
  assign dist_o   = filt_d;
  assign valid_o  = hv_d && ok_d;
  assign age_o    = (!hv_d || (age_diff > {16'd0, AgeSat})) ? AgeSat : age_diff[15:0];

  // Filter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samp_q[0] <= 16'd0;
      samp_q[1] <= 16'd0;
      samp_q[2] <= 16'd0;
      cnt_q     <= 2'd0;
      ws_q      <= 2'd0;
      filt_q    <= 16'd0;
      lvt_q     <= 32'd0;
      hv_q      <= 1'b0;
      ok_q      <= 1'b0;
    end else if (step_i) begin
      samp_q <= samp_d;
      cnt_q  <= cnt_d;
      ws_q   <= ws_d;
      filt_q <= filt_d;
      lvt_q  <= lvt_d;
      hv_q   <= hv_d;
      ok_q   <= ok_d;
    end
  end

endmodule

@@ hdl/urs_seq.sv @@
// ----------------------------------------------------------------------------
// Firing sequencer
// Mode machine, cycle position, slot timing and attempt counter.
// ----------------------------------------------------------------------------
module urs_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  urs_pkg::meas_t    meas_i,
  input  urs_pkg::cfg_t     cfg_i,
  output urs_pkg::seq_res_t res_o,
  output urs_pkg::flt_cmd_t cmd_o
);
  import urs_pkg::*;

  mode_e       mode_q, mode_d, mode0;
  logic        was_q;
  logic [1:0]  pos_q, pos_d, pos0;
  logic [1:0]  act_q, act_d, act0, act_start, act_meas;
  logic [31:0] mst_q, mst_d, mst0, sst_q, sst_d, sst0, now;
  logic [15:0] att_q, att_d;
  logic [2:0]  len, pos1, pos_next, pos_sel;
  logic        chg, run, echo_evt, tmo_evt, guard_ok, start, meas_done, dist_ok;

  assign now = meas_i.item.now_us;
  assign len = cycle_len(cfg_i.present);
  assign chg = (meas_i.item.en != was_q);

  // State after an enable change.
  assign mode0 = chg ? MODE_IDLE : mode_q;
  assign pos0  = chg ? 2'd0 : pos_q;
  assign act0  = chg ? cycle_entry(cfg_i.present, 2'd0) : act_q;
  assign mst0  = chg ? now : mst_q;
  assign sst0  = chg ? now : sst_q;

  // Sequencer events of this tick.
  assign run       = meas_i.item.en && (len != 3'd0);
  assign pos1      = ({1'b0, pos0} >= len) ? 3'd0 : {1'b0, pos0};
  assign echo_evt  = run && (mode0 == MODE_WAIT) && meas_i.item.echo;
  assign tmo_evt   = run && (mode0 == MODE_WAIT) && !meas_i.item.echo &&
                     ((now - mst0) >= {12'd0, cfg_i.timeout_us});
  assign guard_ok  = run && (mode0 == MODE_GUARD) &&
                     ((now - mst0) >= {12'd0, cfg_i.guard_us}) &&
                     ((now - sst0) >= {12'd0, cfg_i.slot_us});
  assign start     = guard_ok || (run && (mode0 == MODE_IDLE));
  assign meas_done = echo_evt || tmo_evt;
  assign pos_next  = ((pos1 + 3'd1) >= len) ? 3'd0 : (pos1 + 3'd1);
  assign pos_sel   = guard_ok ? pos_next : pos1;
  assign act_start = cycle_entry(cfg_i.present, pos_sel[1:0]);
  assign act_meas  = (act0 == 2'd3) ? SensorFront : act0;
  assign dist_ok   = !meas_i.bad && (meas_i.dist_mm <= cfg_i.max_mm);

  // Next state.
  always_comb begin
    mode_d = mode0;
    if (start) begin
      mode_d = MODE_WAIT;
    end else if (meas_done) begin
      mode_d = MODE_GUARD;
    end
    pos_d = run ? pos_sel[1:0] : pos0;
    act_d = start ? act_start : act0;
    mst_d = (start || meas_done) ? now : mst0;
    sst_d = start ? now : sst0;
    att_d = att_q + {15'd0, meas_done};
  end

  // Outputs of this tick.
  always_comb begin
    res_o.fire        = start;
    res_o.fire_sensor = start ? act_start : SensorFront;
    res_o.cancel      = chg || tmo_evt;
    res_o.seq         = att_d;
    cmd_o.clear       = chg && meas_i.item.en;
    cmd_o.done        = meas_done;
    cmd_o.ok          = echo_evt && dist_ok;
    cmd_o.sensor      = act_meas;
    cmd_o.mm          = (meas_i.dist_mm < cfg_i.min_mm) ? cfg_i.min_mm : meas_i.dist_mm;
  end

  // Sequencer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      was_q  <= 1'b0;
      pos_q  <= 2'd0;
      act_q  <= SensorFront;
      mst_q  <= 32'd0;
      sst_q  <= 32'd0;
      att_q  <= 16'd0;
    end else if (step_i) begin
      mode_q <= mode_d;
      was_q  <= meas_i.item.en;
      pos_q  <= pos_d;
      act_q  <= act_d;
      mst_q  <= mst_d;
      sst_q  <= sst_d;
      att_q  <= att_d;
    end
  end

endmodule

@@ hdl/ultrasonic_ranging_sequencer.sv @@
// ----------------------------------------------------------------------------
// Ultrasonic ranging sequencer
// Schedules the fitted sensors, converts echoes to distances and keeps a
// median-of-3 filter per sensor; returns one snapshot per tick.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// tick      in         in_valid_i/in_ready_o  enable, now_us, now_ms, echo
// snapshot  out        out_valid_o/out_ready_i fire, cancel, distances, ages
// config    in         cfg_we_i               cfg_index_i, cfg_wdata_i
//
// One tick is taken per cycle unless a snapshot waits for its transfer; a
// snapshot is valid once past five registers: input register, two multiply
// stages of the distance conversion, quotient fix stage, result register.
// Reset clears all valid flags, the sequencer and the filter stores.
// While a snapshot waits for its transfer, every stage holds and in_ready_o
// is low.
// ----------------------------------------------------------------------------
module ultrasonic_ranging_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [19:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        enable_i,
  input  logic [31:0] now_us_i,
  input  logic [31:0] now_ms_i,
  input  logic        echo_done_i,
  input  logic [31:0] echo_rise_us_i,
  input  logic [31:0] echo_fall_us_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        fire_o,
  output logic [1:0]  fire_sensor_o,
  output logic        cancel_echo_o,
  output logic [15:0] sequence_res_o,
  output logic [15:0] front_mm_o,
  output logic [15:0] left_mm_o,
  output logic [15:0] right_mm_o,
  output logic [2:0]  valid_mask_o,
  output logic [15:0] front_age_ms_o,
  output logic [15:0] left_age_ms_o,
  output logic [15:0] right_age_ms_o
);
  import urs_pkg::*;

  cfg_t        cfg_q;
  item_t       item_in;
  meas_t       meas;
  seq_res_t    sres, sres_q;
  flt_cmd_t    cmd;
  flt_ctl_t    ctl [NumSensors];
  logic [15:0] flt_mm [NumSensors];
  logic [15:0] flt_age [NumSensors];
  logic [15:0] mm_q [NumSensors];
  logic [15:0] age_q [NumSensors];
  logic [2:0]  flt_valid, mask_q;
  logic        adv, meas_valid, step, out_valid_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.present    <= PresentReset;
      cfg_q.max_mm     <= MaxDistReset;
      cfg_q.min_mm     <= MinDistReset;
      cfg_q.timeout_us <= TimeoutReset;
      cfg_q.guard_us   <= GuardReset;
      cfg_q.slot_us    <= SlotReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SENSOR_PRESENT:  cfg_q.present    <= cfg_wdata_i[2:0];
        CFG_MAX_DISTANCE_MM: cfg_q.max_mm     <= cfg_wdata_i[15:0];
        CFG_MIN_DISTANCE_MM: cfg_q.min_mm     <= cfg_wdata_i[15:0];
        CFG_ECHO_TIMEOUT_US: cfg_q.timeout_us <= cfg_wdata_i;
        CFG_GUARD_TIME_US:   cfg_q.guard_us   <= cfg_wdata_i;
        CFG_SLOT_TIME_US:    cfg_q.slot_us    <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // The whole pipeline moves unless a snapshot waits for its transfer.
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign step       = adv && meas_valid;

  assign item_in.en     = enable_i;
  assign item_in.now_us = now_us_i;
  assign item_in.now_ms = now_ms_i;
  assign item_in.echo   = echo_done_i;

  urs_dist u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (in_valid_i),
    .item_i      (item_in),
    .rise_i      (echo_rise_us_i),
    .fall_i      (echo_fall_us_i),
    .out_valid_o (meas_valid),
    .meas_o      (meas)
  );

  urs_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .meas_i (meas),
    .cfg_i  (cfg_q),
    .res_o  (sres),
    .cmd_o  (cmd)
  );

  // One filter per sensor, driven by the decoded measurement outcome.
  for (genvar g = 0; g < NumSensors; g++) begin : g_flt
    assign ctl[g].clear  = cmd.clear;
    assign ctl[g].accept = cmd.done && cmd.ok && (cmd.sensor == 2'(g));
    assign ctl[g].reject = cmd.done && !cmd.ok && (cmd.sensor == 2'(g));
    assign ctl[g].mm     = cmd.mm;

    urs_filter u_filter (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .step_i   (step),
      .ctl_i    (ctl[g]),
      .now_ms_i (meas.item.now_ms),
      .dist_o   (flt_mm[g]),
      .valid_o  (flt_valid[g]),
      .age_o    (flt_age[g])
    );
  end

  // Result register: valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= meas_valid;
    end
  end

  // Result register: payload.
  always_ff @(posedge clk_i) begin
    if (step) begin
      sres_q <= sres;
      mm_q   <= flt_mm;
      age_q  <= flt_age;
      mask_q <= flt_valid;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign fire_o         = sres_q.fire;
  assign fire_sensor_o  = sres_q.fire_sensor;
  assign cancel_echo_o  = sres_q.cancel;
  assign sequence_res_o = sres_q.seq;
  assign front_mm_o     = mm_q[0];
  assign left_mm_o      = mm_q[1];
  assign right_mm_o     = mm_q[2];
  assign valid_mask_o   = mask_q;
  assign front_age_ms_o = age_q[0];
  assign left_age_ms_o  = age_q[1];
  assign right_age_ms_o = age_q[2];

endmodule

@@ hdl/urs_checker.sv @@
// ----------------------------------------------------------------------------
// Ultrasonic ranging sequencer checker
// Port-level assertions on handshake and snapshot sequence, bound to the top.
// ----------------------------------------------------------------------------
module urs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        fire_o,
  input logic [1:0]  fire_sensor_o,
  input logic        cancel_echo_o,
  input logic [15:0] sequence_res_o
);

  logic [15:0] last_seq_q, seq_step;
  logic        have_q, out_xfer;

  assign out_xfer = out_valid_o && out_ready_i;
  assign seq_step = sequence_res_o - last_seq_q;

  // Sequence number of the previous snapshot transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_seq_q <= 16'd0;
      have_q     <= 1'b0;
    end else if (out_xfer) begin
      last_seq_q <= sequence_res_o;
      have_q     <= 1'b1;
    end
  end

  // A stalled snapshot stays and holds its strobes and count.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(fire_o) &&
      $stable(fire_sensor_o) && $stable(cancel_echo_o) && $stable(sequence_res_o))
    else $error("snapshot changed while stalled");

  // With no snapshot pending a tick is always taken.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input not ready with empty result register");

  // Without a trigger the sensor code reads as zero.
  a_no_fire_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !fire_o |-> fire_sensor_o == 2'd0)
    else $error("sensor code set without a trigger");

  // At most one attempt finishes per tick.
  a_seq_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && have_q |-> seq_step == 16'd0 || seq_step == 16'd1)
    else $error("attempt count jumped");

  // A finished attempt leaves guard time, so no trigger in the same tick.
  a_done_no_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && have_q && seq_step == 16'd1 |-> !fire_o)
    else $error("trigger in the tick that finished an attempt");

endmodule

bind ultrasonic_ranging_sequencer urs_checker u_urs_checker (.*);

@@ dv/ultrasonic_ranging_sequencer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ultrasonic ranging sequencer testbench
// Sends timed ticks through the block under ten register settings and checks
// every snapshot against a cycle-free model of the scheduler, the distance
// conversion, the median filters and the ages. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module ultrasonic_ranging_sequencer_tb;
  import urs_pkg::*;

  // Ticks in flight through the block, from the header of the top level.
  localparam int unsigned Latency = 5;
  // Receiver hold-off long enough to fill every stage and stall the input.
  localparam int unsigned HoldOffCycles = 150;

  typedef struct packed {
    bit        en;
    bit [31:0] now_us;
    bit [31:0] now_ms;
    bit        echo;
    bit [31:0] rise_us;
    bit [31:0] fall_us;
  } tick_t;

  typedef struct packed {
    bit        fire;
    bit [1:0]  fire_sensor;
    bit        cancel;
    bit [15:0] attempts;
    bit [15:0] front_mm;
    bit [15:0] left_mm;
    bit [15:0] right_mm;
    bit [2:0]  valid_mask;
    bit [15:0] front_age;
    bit [15:0] left_age;
    bit [15:0] right_age;
  } snapshot_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the registers and of the sequencer and filter
  // state; one expected snapshot per tick transfer.
  // --------------------------------------------------------------------------
  class ranging_scoreboard;
    bit [2:0]    present;
    bit [15:0]   max_mm;
    bit [15:0]   min_mm;
    bit [19:0]   timeout_us;
    bit [19:0]   guard_us;
    bit [19:0]   slot_us;
    mode_e       mode;
    bit          was_en;
    int unsigned cyc_pos;
    bit [1:0]    active;
    bit [31:0]   mode_t0;
    bit [31:0]   slot_t0;
    bit [15:0]   attempts;
    bit [15:0]   samples [3][3];
    int unsigned nsamp [3];
    int unsigned wslot [3];
    bit [15:0]   filt_mm [3];
    bit [31:0]   last_ms [3];
    bit          has_val [3];
    bit          last_ok [3];
    snapshot_t   expected_q [$];
    int unsigned errors, checked, fires, kept, rejected, timeouts;

    function new();
      present    = PresentReset;
      max_mm     = MaxDistReset;
      min_mm     = MinDistReset;
      timeout_us = TimeoutReset;
      guard_us   = GuardReset;
      slot_us    = SlotReset;
      mode       = MODE_IDLE;
      was_en     = 1'b0;
      cyc_pos    = 0;
      active     = SensorFront;
      mode_t0    = '0;
      slot_t0    = '0;
      attempts   = '0;
      clear_filters();
      errors = 0;
      checked = 0;
      fires = 0;
      kept = 0;
      rejected = 0;
      timeouts = 0;
    endfunction

    function void apply_cfg(cfg_idx_e idx, bit [19:0] val);
      case (idx)
        CFG_SENSOR_PRESENT:  present    = val[2:0];
        CFG_MAX_DISTANCE_MM: max_mm     = val[15:0];
        CFG_MIN_DISTANCE_MM: min_mm     = val[15:0];
        CFG_ECHO_TIMEOUT_US: timeout_us = val;
        CFG_GUARD_TIME_US:   guard_us   = val;
        CFG_SLOT_TIME_US:    slot_us    = val;
        default: ;
      endcase
    endfunction

    function void clear_filters();
      for (int s = 0; s < NumSensors; s++) begin
        for (int k = 0; k < 3; k++) samples[s][k] = '0;
        nsamp[s]   = 0;
        wslot[s]   = 0;
        filt_mm[s] = '0;
        last_ms[s] = '0;
        has_val[s] = 1'b0;
        last_ok[s] = 1'b0;
      end
    endfunction

    // Firing order: front, left, front again when right is fitted, right.
    function int unsigned fire_order(output bit [1:0] seq [4]);
      int unsigned n;
      n = 0;
      seq = '{SensorFront, SensorFront, SensorFront, SensorFront};
      if (present[0]) begin
        seq[n] = SensorFront;
        n++;
      end
      if (present[1]) begin
        seq[n] = SensorLeft;
        n++;
      end
      if (present[0] && present[2]) begin
        seq[n] = SensorFront;
        n++;
      end
      if (present[2]) begin
        seq[n] = SensorRight;
        n++;
      end
      return n;
    endfunction

    // First sample as is, then the mean of two, then the median of three.
    function bit [15:0] median_of(int s);
      bit [15:0] a, b, c;
      bit [16:0] sum;
      a = samples[s][0];
      b = samples[s][1];
      c = samples[s][2];
      sum = a + b;
      if (nsamp[s] == 0) return '0;
      if (nsamp[s] == 1) return a;
      if (nsamp[s] == 2) return sum[16:1];
      if ((a <= b && b <= c) || (c <= b && b <= a)) return b;
      if ((b <= a && a <= c) || (c <= a && a <= b)) return a;
      return c;
    endfunction

    function void keep_mm(int s, bit [15:0] mm, bit [31:0] now_ms);
      int unsigned w;
      w = wslot[s] % 3;
      samples[s][w] = mm;
      wslot[s] = (w + 1 >= 3) ? 0 : w + 1;
      if (nsamp[s] < 3) nsamp[s]++;
      filt_mm[s] = median_of(s);
      last_ms[s] = now_ms;
      has_val[s] = 1'b1;
      last_ok[s] = 1'b1;
    endfunction

    function bit [15:0] age_of(int s, bit [31:0] now_ms);
      bit [31:0] d;
      d = now_ms - last_ms[s];
      if (!has_val[s]) return AgeSat;
      return (d > 32'd65535) ? AgeSat : d[15:0];
    endfunction

    // Advance the model by one tick and queue the snapshot it gives.
    function void note_tick(tick_t t);
      bit [1:0]    seq [4];
      int unsigned n;
      int          s;
      bit          start;
      bit [31:0]   pulse;
      bit [63:0]   dist_mm;
      bit [15:0]   mm;
      bit [31:0]   since_mode;
      bit [31:0]   since_slot;
      snapshot_t   exp;
      n = fire_order(seq);
      start = 1'b0;
      exp = '0;

      // An enable change aborts the capture and restarts the cycle.
      if (t.en != was_en) begin
        was_en = t.en;
        exp.cancel = 1'b1;
        mode = MODE_IDLE;
        active = (n > 0) ? seq[0] : SensorFront;
        cyc_pos = 0;
        mode_t0 = t.now_us;
        slot_t0 = t.now_us;
        if (t.en) clear_filters();
      end

      // Sequencer.
      if (t.en && n > 0) begin
        if (cyc_pos >= n) cyc_pos = 0;
        since_mode = t.now_us - mode_t0;
        since_slot = t.now_us - slot_t0;
        s = (active < NumSensors) ? active : 0;
        case (mode)
          MODE_WAIT: begin
            if (t.echo) begin
              // Distance in mm: (pulse * 343 + 1000) / 2000, exact.
              pulse = t.fall_us - t.rise_us;
              dist_mm = ({32'd0, pulse} * 64'd343 + 64'd1000) / 64'd2000;
              if (pulse == 0 || dist_mm > {48'd0, max_mm}) begin
                last_ok[s] = 1'b0;
                rejected++;
              end else begin
                mm = dist_mm[15:0];
                if (mm < min_mm) mm = min_mm;
                keep_mm(s, mm, t.now_ms);
                kept++;
              end
              attempts++;
              mode = MODE_GUARD;
              mode_t0 = t.now_us;
            end else if (since_mode >= {12'd0, timeout_us}) begin
              exp.cancel = 1'b1;
              last_ok[s] = 1'b0;
              attempts++;
              mode = MODE_GUARD;
              mode_t0 = t.now_us;
              timeouts++;
            end
          end
          MODE_GUARD: begin
            if (since_mode >= {12'd0, guard_us} && since_slot >= {12'd0, slot_us}) begin
              cyc_pos++;
              if (cyc_pos >= n) cyc_pos = 0;
              start = 1'b1;
            end
          end
          default: start = 1'b1;
        endcase
        if (start) begin
          active = seq[cyc_pos % 4];
          exp.fire = 1'b1;
          exp.fire_sensor = active;
          mode = MODE_WAIT;
          mode_t0 = t.now_us;
          slot_t0 = t.now_us;
          fires++;
        end
      end

      // Snapshot.
      exp.attempts = attempts;
      exp.front_mm = filt_mm[SensorFront];
      exp.left_mm  = filt_mm[SensorLeft];
      exp.right_mm = filt_mm[SensorRight];
      for (int k = 0; k < NumSensors; k++) exp.valid_mask[k] = has_val[k] && last_ok[k];
      exp.front_age = age_of(SensorFront, t.now_ms);
      exp.left_age  = age_of(SensorLeft, t.now_ms);
      exp.right_age = age_of(SensorRight, t.now_ms);
      expected_q.push_back(exp);
    endfunction

    function void compare(string name, bit [31:0] exp_v, bit [31:0] got_v);
      if (exp_v != got_v) begin
        errors++;
        $display("%0t: snapshot %0d %s expected %0d, got %0d", $time, checked, name,
                 exp_v, got_v);
      end
    endfunction

    function void check_snapshot(snapshot_t got);
      snapshot_t exp;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: snapshot transfer with no tick outstanding (fire %0b, seq %0d)",
                 $time, got.fire, got.attempts);
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      compare("fire", exp.fire, got.fire);
      compare("fire_sensor", exp.fire_sensor, got.fire_sensor);
      compare("cancel_echo", exp.cancel, got.cancel);
      compare("sequence", exp.attempts, got.attempts);
      compare("front_mm", exp.front_mm, got.front_mm);
      compare("left_mm", exp.left_mm, got.left_mm);
      compare("right_mm", exp.right_mm, got.right_mm);
      compare("valid_mask", exp.valid_mask, got.valid_mask);
      compare("front_age_ms", exp.front_age, got.front_age);
      compare("left_age_ms", exp.left_age, got.left_age);
      compare("right_age_ms", exp.right_age, got.right_age);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test
  // --------------------------------------------------------------------------
  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [19:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        enable_i;
  logic [31:0] now_us_i;
  logic [31:0] now_ms_i;
  logic        echo_done_i;
  logic [31:0] echo_rise_us_i;
  logic [31:0] echo_fall_us_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        fire_o;
  logic [1:0]  fire_sensor_o;
  logic        cancel_echo_o;
  logic [15:0] sequence_res_o;
  logic [15:0] front_mm_o;
  logic [15:0] left_mm_o;
  logic [15:0] right_mm_o;
  logic [2:0]  valid_mask_o;
  logic [15:0] front_age_ms_o;
  logic [15:0] left_age_ms_o;
  logic [15:0] right_age_ms_o;

  ultrasonic_ranging_sequencer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .enable_i       (enable_i),
    .now_us_i       (now_us_i),
    .now_ms_i       (now_ms_i),
    .echo_done_i    (echo_done_i),
    .echo_rise_us_i (echo_rise_us_i),
    .echo_fall_us_i (echo_fall_us_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .fire_o         (fire_o),
    .fire_sensor_o  (fire_sensor_o),
    .cancel_echo_o  (cancel_echo_o),
    .sequence_res_o (sequence_res_o),
    .front_mm_o     (front_mm_o),
    .left_mm_o      (left_mm_o),
    .right_mm_o     (right_mm_o),
    .valid_mask_o   (valid_mask_o),
    .front_age_ms_o (front_age_ms_o),
    .left_age_ms_o  (left_age_ms_o),
    .right_age_ms_o (right_age_ms_o)
  );

  ranging_scoreboard sb;

  // Stimulus state: current time base and shaping knobs of the phase.
  bit [31:0]   cur_us;
  bit [31:0]   cur_ms;
  bit          cur_en;
  int unsigned us_step;
  int unsigned echo_pct;
  int unsigned burst_left;
  int unsigned ticks_sent;
  int unsigned settings_used;

  // 10 ns clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Check each snapshot transfer.
  always @(posedge clk_i) begin
    snapshot_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.fire        = fire_o;
      got.fire_sensor = fire_sensor_o;
      got.cancel      = cancel_echo_o;
      got.attempts    = sequence_res_o;
      got.front_mm    = front_mm_o;
      got.left_mm     = left_mm_o;
      got.right_mm    = right_mm_o;
      got.valid_mask  = valid_mask_o;
      got.front_age   = front_age_ms_o;
      got.left_age    = left_age_ms_o;
      got.right_age   = right_age_ms_o;
      sb.check_snapshot(got);
    end
  end

  // Receiver: stretches of steady, random and sparse ready, with a long
  // hold-off now and then while ticks are being offered.
  initial begin
    int unsigned kind;
    int unsigned span;
    int unsigned stretch;
    out_ready_i = 1'b0;
    stretch = 0;
    forever begin
      kind = $urandom_range(0, 3);
      span = $urandom_range(10, 80);
      stretch++;
      if (stretch % 12 == 6) begin
        @(negedge clk_i);
        while (!in_valid_i) @(negedge clk_i);
        repeat (HoldOffCycles) begin
          out_ready_i <= 1'b0;
          @(negedge clk_i);
        end
      end else begin
        repeat (span) begin
          @(negedge clk_i);
          case (kind)
            0: out_ready_i <= 1'b1;
            1: out_ready_i <= 1'($urandom_range(0, 1));
            2: out_ready_i <= ($urandom_range(0, 3) != 0);
            default: out_ready_i <= ($urandom_range(0, 4) == 0);
          endcase
        end
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // One tick transfer, preceded by a random gap at the end of each burst.
  task automatic send_tick(input tick_t t);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 6)) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    enable_i       <= t.en;
    now_us_i       <= t.now_us;
    now_ms_i       <= t.now_ms;
    echo_done_i    <= t.echo;
    echo_rise_us_i <= t.rise_us;
    echo_fall_us_i <= t.fall_us;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_tick(t);
    ticks_sent++;
  endtask

  // Wait until every snapshot is back and the pipeline has gone quiet.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input bit [19:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.apply_cfg(idx, val);
  endtask

  task automatic set_regs(input bit [2:0] p, input bit [15:0] mx, input bit [15:0] mn,
                          input bit [19:0] tmo, input bit [19:0] grd,
                          input bit [19:0] slt);
    drain();
    write_cfg(CFG_SENSOR_PRESENT, {17'd0, p});
    write_cfg(CFG_MAX_DISTANCE_MM, {4'd0, mx});
    write_cfg(CFG_MIN_DISTANCE_MM, {4'd0, mn});
    write_cfg(CFG_ECHO_TIMEOUT_US, tmo);
    write_cfg(CFG_GUARD_TIME_US, grd);
    write_cfg(CFG_SLOT_TIME_US, slt);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Directed tick; the random part carries on from its time base.
  function automatic tick_t tick_at(bit en, bit [31:0] us, bit [31:0] ms, bit echo,
                                    bit [31:0] rise, bit [31:0] fall);
    tick_t t;
    t = '{en: en, now_us: us, now_ms: ms, echo: echo, rise_us: rise, fall_us: fall};
    cur_en = en;
    cur_us = us;
    cur_ms = ms;
    return t;
  endfunction

  // Echo length: zero, short, around the maximum distance, or anything.
  function automatic bit [31:0] pick_pulse();
    int unsigned lim;
    int unsigned span;
    lim  = ((sb.max_mm + 1) * 2000 - 1000 + 342) / 343;
    span = (sb.max_mm * 2000) / 343 + 50;
    case ($urandom_range(0, 9))
      0: return '0;
      1, 2, 3: return $urandom_range(1, 200);
      4: return $urandom;
      5: return lim + $urandom_range(0, 3) - 2;
      default: return $urandom_range(1, span);
    endcase
  endfunction

  // Mostly well-formed ranging: time moves on, echoes come while a capture
  // is armed; some noise echoes and enable toggles on top.
  function automatic tick_t next_tick();
    tick_t t;
    if ($urandom_range(0, 99) == 0) cur_us = cur_us + $urandom;
    else cur_us = cur_us + $urandom_range(0, us_step);
    if ($urandom_range(0, 39) == 0) cur_ms = cur_ms + $urandom_range(0, 100000);
    else cur_ms = cur_ms + $urandom_range(0, 3);
    if (cur_en) cur_en = ($urandom_range(0, 79) != 0);
    else cur_en = ($urandom_range(0, 5) == 0);
    t.en = cur_en;
    t.now_us = cur_us;
    t.now_ms = cur_ms;
    if (sb.was_en && cur_en && sb.mode == MODE_WAIT) t.echo = ($urandom_range(0, 99) < echo_pct);
    else t.echo = ($urandom_range(0, 19) == 0);
    t.rise_us = $urandom;
    t.fall_us = t.rise_us + pick_pulse();
    return t;
  endfunction

  task automatic random_ticks(input int unsigned step, input int unsigned pct,
                              input int unsigned count);
    us_step  = step;
    echo_pct = pct;
    repeat (count) send_tick(next_tick());
  endtask

  task automatic run_phase(input bit [2:0] p, input bit [15:0] mx, input bit [15:0] mn,
                           input bit [19:0] tmo, input bit [19:0] grd,
                           input bit [19:0] slt, input int unsigned step,
                           input int unsigned pct, input int unsigned count);
    set_regs(p, mx, mn, tmo, grd, slt);
    random_ticks(step, pct, count);
  endtask

  initial begin
    sb = new();
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = CFG_SENSOR_PRESENT;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    enable_i       = 1'b0;
    now_us_i       = '0;
    now_ms_i       = '0;
    echo_done_i    = 1'b0;
    echo_rise_us_i = '0;
    echo_fall_us_i = '0;
    cur_us = '0;
    cur_ms = '0;
    cur_en = 1'b0;
    burst_left = 0;
    ticks_sent = 0;
    settings_used = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed ticks on short timing: echo while disabled, zero pulse, echo
    // in guard, echo together with timeout, wrapped pulse, raise to minimum,
    // timeout, distances at and just past the maximum, time and age wrap,
    // enable toggles in guard and in wait.
    set_regs(3'd7, 16'd4000, 16'd20, 20'd100, 20'd30, 20'd80);
    send_tick(tick_at(1'b0, 32'd0, 32'd0, 1'b1, 32'd0, 32'hFFFF_FFFF));
    send_tick(tick_at(1'b1, 32'd10, 32'd1, 1'b0, 32'd0, 32'd0));
    send_tick(tick_at(1'b1, 32'd20, 32'd2, 1'b1, 32'd5, 32'd5));
    send_tick(tick_at(1'b1, 32'd30, 32'd3, 1'b1, 32'd100, 32'd50000));
    send_tick(tick_at(1'b1, 32'd200, 32'd4, 1'b0, 32'd0, 32'd0));
    send_tick(tick_at(1'b1, 32'd300, 32'd5, 1'b1, 32'd1000, 32'd2000));
    send_tick(tick_at(1'b1, 32'd400, 32'd6, 1'b0, 32'd0, 32'd0));
    send_tick(tick_at(1'b1, 32'd410, 32'd7, 1'b1, 32'd1, 32'd0));
    send_tick(tick_at(1'b1, 32'd500, 32'd8, 1'b0, 32'd0, 32'd0));
    send_tick(tick_at(1'b1, 32'd510, 32'd9, 1'b1, 32'd0, 32'd1));
    send_tick(tick_at(1'b1, 32'd600, 32'd10, 1'b0, 32'd0, 32'd0));
    send_tick(tick_at(1'b1, 32'd700, 32'd11, 1'b0, 32'd0, 32'd0));
    send_tick(tick_at(1'b1, 32'd790, 32'd12, 1'b0, 32'd0, 32'd0));
    send_tick(tick_at(1'b1, 32'd800, 32'd13, 1'b1, 32'd0, 32'd23320));
    send_tick(tick_at(1'b1, 32'd900, 32'd14, 1'b0, 32'd0, 32'd0));
    send_tick(tick_at(1'b1, 32'd910, 32'hFFFF_FFFF, 1'b1, 32'd0, 32'd23326));
    send_tick(tick_at(1'b1, 32'd1000, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd0));
    send_tick(tick_at(1'b1, 32'd1010, 32'd0, 1'b1, 32'hFFFF_FFFF, 32'd23326));
    send_tick(tick_at(1'b0, 32'd1020, 32'd1, 1'b0, 32'd0, 32'd0));
    send_tick(tick_at(1'b1, 32'hFFFF_FFC0, 32'd2, 1'b0, 32'd0, 32'd0));
    send_tick(tick_at(1'b1, 32'hFFFF_FFF0, 32'd3, 1'b1, 32'd10, 32'd1000));
    send_tick(tick_at(1'b1, 32'h0000_0040, 32'd4, 1'b0, 32'd0, 32'd0));
    send_tick(tick_at(1'b0, 32'h0000_0050, 32'd5, 1'b1, 32'd7, 32'd900));
    random_ticks(40, 55, 120);

    // Random phases; the fitted set changes while the cycle is running.
    run_phase(3'd7, 16'd4000, 16'd20, 20'd30000, 20'd10000, 20'd60000, 12000, 45, 120);
    run_phase(3'd1, 16'hFFFF, 16'd0, 20'hFFFFF, 20'd0, 20'd0, 300000, 50, 100);
    run_phase(3'd6, 16'd0, 16'hFFFF, 20'd0, 20'hFFFFF, 20'hFFFFF, 400000, 60, 100);
    run_phase(3'd0, 16'd4000, 16'd20, 20'd100, 20'd30, 20'd80, 40, 50, 40);
    cur_us = 32'hFFFF_F000;
    run_phase(3'd5, 16'd1000, 16'd500, 20'd50, 20'd10, 20'd100, 30, 55, 120);
    run_phase(3'd3, 16'd200, 16'd100, 20'd60, 20'd20, 20'd40, 25, 50, 110);
    run_phase(3'd7, 16'hFFFF, 16'hFFFF, 20'd20, 20'd0, 20'd0, 10, 60, 120);
    run_phase(3'd4, 16'd4000, 16'd20, 20'd80, 20'd25, 20'd50, 30, 40, 100);
    run_phase(3'd2, 16'd3000, 16'd50, 20'd150, 20'd40, 20'd120, 50, 45, 100);

    drain();
    $display("Covered %0d ticks under %0d register settings, %0d snapshots checked.",
             ticks_sent, settings_used, sb.checked);
    $display("Sensors fired %0d times: %0d echoes kept, %0d rejected, %0d timed out.",
             sb.fires, sb.kept, sb.rejected, sb.timeouts);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/urs_pkg.sv
hdl/urs_dist.sv
hdl/urs_filter.sv
hdl/urs_seq.sv
hdl/ultrasonic_ranging_sequencer.sv
hdl/urs_checker.sv
dv/ultrasonic_ranging_sequencer_tb.sv
